[src/assert_macros.svh]
// Assertion helper macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[src/pcr_pkg.sv]
package pcr_pkg;
  localparam int unsigned PW = 16;
  localparam int unsigned ONE_Q15 = 32768;
  localparam logic [3:0] REG_THR = 4'd0;
  localparam logic [3:0] REG_UVM = 4'd1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SORT = 5'b00010,
    ST_MED  = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_WAIT = 5'b10000
  } state_e;

  function automatic logic [15:0] one_minus(input logic [15:0] m);
    logic [16:0] d;
    d = 17'(ONE_Q15) - {1'b0, m};
    return (m >= 16'(ONE_Q15)) ? 16'd0 : d[15:0];
  endfunction
endpackage

[src/pcr_median.sv]
// Median over the window by rank counting, one element per cycle.
module pcr_median #(
  parameter int unsigned LEN = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [LEN*16-1:0] win_i,
  output logic done_o,
  output logic [15:0] med_o
);
  import pcr_pkg::*;
  localparam int unsigned IW = (LEN > 1) ? $clog2(LEN) : 1;
  localparam int unsigned LO = (LEN - 1) / 2;
  localparam int unsigned HI = LEN / 2;
  logic busy_q, busy_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [15:0] lo_q, lo_d, hi_q, hi_d;
  logic [15:0] x;
  logic [4:0] lt, le;
  logic [16:0] sum;

  always_comb begin
    x  = win_i[idx_q*16 +: 16];
    lt = '0;
    le = '0;
    for (int k = 0; k < LEN; k++) begin
      if (win_i[k*16 +: 16] < x) lt = lt + 5'd1;
      if (win_i[k*16 +: 16] <= x) le = le + 5'd1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    idx_d = idx_q;
    lo_d = lo_q;
    hi_d = hi_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d = '0;
    end else if (busy_q) begin
      // x sits at sorted ranks lt..le-1
      if (lt <= 5'(LO) && le > 5'(LO)) lo_d = x;
      if (lt <= 5'(HI) && le > 5'(HI)) hi_d = x;
      if (idx_q == IW'(LEN - 1)) busy_d = 1'b0;
      else idx_d = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  logic busy_p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_p_q <= 1'b0;
    else busy_p_q <= busy_q;
  end
  assign done_o = busy_p_q && !busy_q;
  assign sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign med_o = sum[16:1];
endmodule

[src/pitch_candidate_refine_core.sv]
// Sequence: each candidate beat is stored; a last or flush beat then takes up to
// MAX_CANDS sort steps, MEDIAN_LEN median steps, then MAX_CANDS result beats if the delayed slot holds a frame.
// Input is stalled from a last or flush beat until the frame's results are emitted;
// the insertion sort and the one-element-per-cycle median ranker run in turn.
// Reset: asynchronous active low; clears counts, window, delay-valid mask and
// state, and sets the config registers to their reset values; frame and delay-line data are not reset.
`include "assert_macros.svh"
module pitch_candidate_refine_core #(
  parameter int unsigned MAX_CANDS = 8,
  parameter int unsigned MEDIAN_LEN = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [3:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic cmd_i,
  input  logic [15:0] cand_pitch_i,
  input  logic [15:0] cand_merit_i,
  input  logic last_cand_i,
  input  logic [15:0] frame_energy_i,
  input  logic [15:0] spec_pitch_i,
  input  logic voiced_by_energy_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [2:0] out_slot_o,
  output logic [15:0] out_pitch_o,
  output logic [15:0] out_merit_o,
  output logic frame_done_o
);
  import pcr_pkg::*;
  localparam int unsigned CW = $clog2(MAX_CANDS + 1);
  localparam int unsigned SW = $clog2(MAX_CANDS);
  localparam int unsigned DELAY = (MEDIAN_LEN - 1) / 2;
  localparam int unsigned SLOTS = DELAY + 1;
  localparam logic [18:0] RECIP5 = 19'd419431;

  state_e st_q, st_d;
  logic [15:0] thr_q, uvm_q;
  logic [15:0] lp_q [MAX_CANDS];
  logic [15:0] lm_q [MAX_CANDS];
  logic [CW-1:0] lcnt_q;
  // sorted frame under construction
  logic [15:0] fp_q [MAX_CANDS];
  logic [15:0] fm_q [MAX_CANDS];
  logic [CW-1:0] si_q;
  logic [15:0] dp_q [SLOTS][MAX_CANDS];
  logic [15:0] dm_q [SLOTS][MAX_CANDS];
  logic [15:0] de_q [SLOTS];
  logic [15:0] ds_q [SLOTS];
  logic        dv_q [SLOTS];
  logic [SLOTS-1:0] seen_q;
  logic [MEDIAN_LEN*16-1:0] win_q;
  logic is_flush_q;
  logic [15:0] e_q, sp_q;
  logic v_q;
  logic [SW-1:0] oi_q;
  logic [15:0] best_q;
  logic med_start, med_done;
  logic [15:0] med;
  logic acc_in, acc_out;

  assign acc_in = in_valid_i && !in_stall_o;
  assign acc_out = out_valid_o && !out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE);

  pcr_median #(.LEN(MEDIAN_LEN)) u_med (
    .clk_i, .rst_ni, .start_i(med_start), .win_i(win_q),
    .done_o(med_done), .med_o(med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd26;
      uvm_q <= 16'd32440;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_THR) thr_q <= cfg_data_i;
      else if (cfg_idx_i == REG_UVM) uvm_q <= cfg_data_i;
    end
  end

  // one insertion step per cycle: candidate si enters at its place
  logic [15:0] cp, cm;
  logic [MAX_CANDS-1:0] shift;
  always_comb begin
    cp = lp_q[si_q[SW-1:0]];
    cm = lm_q[si_q[SW-1:0]];
    for (int j = 0; j < MAX_CANDS; j++)
      shift[j] = (CW'(j) <= si_q) && (j > 0) && (fm_q[(j > 0) ? j - 1 : 0] < cm);
  end

  always_comb begin
    st_d = st_q;
    med_start = 1'b0;
    unique case (st_q)
      ST_IDLE: if (acc_in && (cmd_i || last_cand_i)) st_d = ST_SORT;
      ST_SORT: if (is_flush_q || si_q == lcnt_q) begin
        st_d = ST_MED;
        med_start = 1'b1;
      end
      ST_MED: if (med_done) st_d = seen_q[DELAY] ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (acc_out && oi_q == SW'(MAX_CANDS - 1)) st_d = ST_IDLE;
      ST_WAIT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      lcnt_q <= '0;
      si_q <= '0;
      seen_q <= '0;
      win_q <= '0;
      oi_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_IDLE && acc_in && !cmd_i) begin
        if (lcnt_q < CW'(MAX_CANDS)) lcnt_q <= lcnt_q + CW'(1);
        si_q <= '0;
      end
      if (st_q == ST_IDLE && acc_in && cmd_i) si_q <= '0;
      if (st_q == ST_SORT && !(is_flush_q || si_q == lcnt_q)) si_q <= si_q + CW'(1);
      if (med_start) begin
        // enter frame into window and delay line
        win_q <= (MEDIAN_LEN*16)'({win_q, (is_flush_q ? 16'd0 : fp_q[0])});
        seen_q <= SLOTS'({seen_q, !is_flush_q});
        if (!is_flush_q) lcnt_q <= '0;
      end
      if (st_q == ST_MED) oi_q <= '0;
      if (acc_out) oi_q <= oi_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && acc_in) begin
      is_flush_q <= cmd_i;
      e_q <= frame_energy_i;
      sp_q <= spec_pitch_i;
      v_q <= voiced_by_energy_i;
      for (int j = 0; j < MAX_CANDS; j++) begin
        fp_q[j] <= '0;
        fm_q[j] <= '0;
      end
      if (!cmd_i && lcnt_q < CW'(MAX_CANDS)) begin
        lp_q[lcnt_q[SW-1:0]] <= cand_pitch_i;
        lm_q[lcnt_q[SW-1:0]] <= cand_merit_i;
      end
    end
    if (st_q == ST_SORT && !(is_flush_q || si_q == lcnt_q)) begin
      for (int j = 0; j < MAX_CANDS; j++) begin
        if (shift[j]) begin
          fp_q[j] <= fp_q[(j > 0) ? j - 1 : 0];
          fm_q[j] <= fm_q[(j > 0) ? j - 1 : 0];
        end else if (CW'(j) <= si_q && (j == 0 || !shift[(j > 0) ? j - 1 : 0])
                     && (CW'(j) == si_q || shift[(j < MAX_CANDS - 1) ? j + 1 : j])) begin
          fp_q[j] <= cp;
          fm_q[j] <= cm;
        end
      end
    end
    if (med_start) begin
      for (int s = SLOTS - 1; s > 0; s--) begin
        dp_q[s] <= dp_q[s-1];
        dm_q[s] <= dm_q[s-1];
        de_q[s] <= de_q[s-1];
        ds_q[s] <= ds_q[s-1];
        dv_q[s] <= dv_q[s-1];
      end
      for (int j = 0; j < MAX_CANDS; j++) begin
        dp_q[0][j] <= is_flush_q ? 16'd0 : fp_q[j];
        dm_q[0][j] <= is_flush_q ? 16'd0 : fm_q[j];
      end
      de_q[0] <= is_flush_q ? 16'd0 : e_q;
      ds_q[0] <= is_flush_q ? 16'd0 : sp_q;
      dv_q[0] <= is_flush_q ? 1'b0 : v_q;
    end
    if (med_done) best_q <= dv_q[DELAY] ? med : 16'd0;
  end

  // refinement for result oi_q
  logic [15:0] e, half, omh, p, m, q;
  logic [18:0] e128;
  logic [37:0] prod;
  always_comb begin
    e = de_q[DELAY];
    half = (e > 16'd512) ? 16'(ONE_Q15) : 16'({e, 6'd0});
    omh = one_minus(half);
    // e*128/5 by reciprocal; exact below the saturation point e = 2560
    e128 = {e[11:0], 7'd0};
    prod = {19'd0, e128} * {19'd0, RECIP5};
    q = prod[36:21];
    p = dp_q[DELAY][oi_q];
    m = dm_q[DELAY][oi_q];
    if (e <= thr_q) begin
      p = '0;
      m = uvm_q;
    end else if (dp_q[DELAY][0] != 16'd0) begin
      if (oi_q == SW'(MAX_CANDS - 1)) begin
        p = '0;
        m = one_minus(dm_q[DELAY][0]);
      end else if (oi_q != '0 && p == 16'd0) m = '0;
    end else if (oi_q == '0) begin
      p = ds_q[DELAY];
      m = half;
    end else begin
      p = '0;
      m = omh;
    end
    if (oi_q == SW'(MAX_CANDS - 2)) begin
      p = best_q;
      m = (best_q != 16'd0) ? ((e <= thr_q) ? uvm_q :
          (dp_q[DELAY][0] != 16'd0) ? dm_q[DELAY][0] : half) : omh;
    end
    if (oi_q == SW'(MAX_CANDS - 3)) begin
      p = ds_q[DELAY];
      m = (e >= 16'd2560) ? 16'hFFFF : q;
    end
  end

  assign out_valid_o = (st_q == ST_EMIT);
  assign out_slot_o = 3'(oi_q);
  assign out_pitch_o = p;
  assign out_merit_o = m;
  assign frame_done_o = (oi_q == SW'(MAX_CANDS - 1));

  `ASSERT_NEVER(a_no_in_busy, acc_in && st_q != ST_IDLE, "beat accepted while busy")
  `ASSERT_IMPL(a_emit_seen, (st_q == ST_EMIT) |-> seen_q[DELAY], "emit of empty slot")
  `ASSERT_IMPL(a_cnt_bound, 1'b1 |-> (lcnt_q <= CW'(MAX_CANDS)), "load count overflow")
endmodule
